// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; clock and reset are passed in by the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define KCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication, disabled during reset
`define KCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- sv/kct_pkg.sv -----
// shared types and constants of the keyed count table
// no dependencies
`default_nettype none

package kct_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W   = 32;
    localparam int CNT_W   = 31;
    localparam int AMT_W   = 16;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

    // request codes, code 3 behaves as a query
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_REM   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // result status codes
    localparam logic [1:0] STS_DONE    = 2'd0;
    localparam logic [1:0] STS_REFUSED = 2'd1;
    localparam logic [1:0] STS_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [KEY_W-1:0] item_key;
        logic [AMT_W-1:0]        amount;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] count_after;
    } t_rsp;

    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic [CNT_W-1:0]        count;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_entry           entry;
    } t_tbl_wr;

endpackage

`default_nettype wire

// ----- sv/kct_table.sv -----
// entry storage: one write port, one registered read port
// depends on kct_pkg
`default_nettype none

module kct_table (
    input  wire logic                      i_clk,
    input  wire logic [kct_pkg::IDX_W-1:0] i_rd_idx,
    output kct_pkg::t_entry                o_rd,
    input  wire kct_pkg::t_tbl_wr          i_wr
);
    import kct_pkg::*;

    t_entry r_mem [ENTRIES];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_rd_idx];
    end

    assign o_rd = r_rd;

endmodule

`default_nettype wire

// ----- sv/kct_alu.sv -----
// count arithmetic: one adder/subtractor with saturation and borrow flag
// depends on kct_pkg
`default_nettype none

module kct_alu (
    input  wire logic                      i_sub,
    input  wire logic [kct_pkg::CNT_W-1:0] i_cnt,
    input  wire logic [kct_pkg::AMT_W-1:0] i_amt,
    output logic      [kct_pkg::CNT_W-1:0] o_value,
    output logic                           o_flag
);
    import kct_pkg::*;

    logic [CNT_W:0] a_ext;
    logic [CNT_W:0] b_ext;
    logic [CNT_W:0] res;

    assign a_ext = {1'b0, i_cnt};
    assign b_ext = {{(CNT_W + 1 - AMT_W){1'b0}}, i_amt};
    assign res   = i_sub ? (a_ext - b_ext) : (a_ext + b_ext);

    // carry on add means saturate, borrow on subtract means count < amount
    assign o_flag  = res[CNT_W];
    assign o_value = (!i_sub && res[CNT_W]) ? CNT_MAX : res[CNT_W-1:0];

endmodule

`default_nettype wire

// ----- sv/keyed_count_table.sv -----
// keyed count table top level: sequencer, match tracking and result register
// depends on kct_pkg, kct_table, kct_alu
//
// A table of ENTRIES keys with a 31-bit count each. Every request (add,
// remove or query) gives exactly one result with a status and the key's
// count afterwards. A request is accepted, then the table is walked through
// its single read port one entry per cycle, then the last entry is compared,
// and then the entry is updated and the result register loaded once the
// previous result has left it. The request side is stalled while a request
// is in work; a finished result may wait in the result register while the
// next request is taken. After reset a clearing pass marks every entry free,
// and requests are stalled until it ends. Lookup picks the lowest matching
// valid entry, a new key takes the lowest free entry, and counts saturate at
// 2^31-1.
`default_nettype none

module keyed_count_table (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_req_valid,
    output logic       o_req_stall,
    input  wire kct_pkg::t_req i_req,
    output logic       o_rsp_valid,
    input  wire logic  i_rsp_stall,
    output kct_pkg::t_rsp o_rsp
);
    import kct_pkg::*;

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_LAST  = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;

    logic [2:0]       r_state,      n_state;
    logic [IDX_W-1:0] r_idx,        n_idx;
    t_req             r_req,        n_req;
    logic             r_cmp_act,    n_cmp_act;
    logic [IDX_W-1:0] r_cmp_idx,    n_cmp_idx;
    logic             r_found,      n_found;
    logic [IDX_W-1:0] r_found_idx,  n_found_idx;
    logic [CNT_W-1:0] r_cnt,        n_cnt;
    logic             r_free_found, n_free_found;
    logic [IDX_W-1:0] r_free_idx,   n_free_idx;
    t_rsp             r_rsp,        n_rsp;
    logic             r_rsp_valid,  n_rsp_valid;

    t_entry           rd_entry;
    t_tbl_wr          tbl_wr;
    logic [CNT_W-1:0] alu_value;
    logic             alu_flag;
    logic             hit;
    logic             free_hit;
    logic             out_free;

    kct_table u_table (
        .i_clk    (i_clk),
        .i_rd_idx (r_idx),
        .o_rd     (rd_entry),
        .i_wr     (tbl_wr)
    );

    // one add/subtract unit serves both add and remove
    kct_alu u_alu (
        .i_sub   (r_req.req_type == OP_REM),
        .i_cnt   (r_cnt),
        .i_amt   (r_req.amount),
        .o_value (alu_value),
        .o_flag  (alu_flag)
    );

    // read data comes back in the cycle after its scan address
    assign hit      = r_cmp_act && rd_entry.valid && (rd_entry.key == r_req.item_key)
                      && !r_found;
    assign free_hit = r_cmp_act && !rd_entry.valid && !r_free_found;
    assign out_free = !r_rsp_valid || !i_rsp_stall;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_req        = r_req;
        n_cmp_act    = (r_state == S_SCAN);
        n_cmp_idx    = r_idx;
        n_found      = r_found;
        n_found_idx  = r_found_idx;
        n_cnt        = r_cnt;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_rsp        = r_rsp;
        n_rsp_valid  = r_rsp_valid && i_rsp_stall;

        tbl_wr       = '0;
        tbl_wr.idx   = r_idx;

        // lowest matching entry and lowest free entry
        if (hit) begin
            n_found     = 1'b1;
            n_found_idx = r_cmp_idx;
            n_cnt       = rd_entry.count;
        end
        if (free_hit) begin
            n_free_found = 1'b1;
            n_free_idx   = r_cmp_idx;
        end

        case (r_state)
            S_CLEAR: begin
                // write every entry free, one a cycle
                tbl_wr.en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req        = i_req;
                    n_idx        = '0;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_LAST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_LAST: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                // hold here while the previous result is still waiting
                if (out_free) begin
                    n_rsp_valid = 1'b1;
                    n_state     = S_IDLE;
                    n_idx       = '0;
                    n_rsp.status      = STS_DONE;
                    n_rsp.count_after = r_found ? r_cnt : '0;
                    case (r_req.req_type)
                        OP_ADD: begin
                            tbl_wr.en        = 1'b1;
                            tbl_wr.entry.key = r_req.item_key;
                            if (r_found) begin
                                tbl_wr.idx         = r_found_idx;
                                tbl_wr.entry.valid = 1'b1;
                                tbl_wr.entry.count = alu_value;
                                n_rsp.count_after  = alu_value;
                            end else if (r_free_found) begin
                                tbl_wr.idx         = r_free_idx;
                                tbl_wr.entry.valid = 1'b1;
                                tbl_wr.entry.count = CNT_W'(r_req.amount);
                                n_rsp.count_after  = CNT_W'(r_req.amount);
                            end else begin
                                tbl_wr.en         = 1'b0;
                                n_rsp.status      = STS_FULL;
                                n_rsp.count_after = '0;
                            end
                        end
                        OP_REM: begin
                            if (r_found && !alu_flag) begin
                                // entry is freed when its count reaches zero
                                tbl_wr.en          = 1'b1;
                                tbl_wr.idx         = r_found_idx;
                                tbl_wr.entry.valid = (alu_value != '0);
                                tbl_wr.entry.key   = r_req.item_key;
                                tbl_wr.entry.count = alu_value;
                                n_rsp.count_after  = alu_value;
                            end else begin
                                n_rsp.status = STS_REFUSED;
                            end
                        end
                        default: begin
                            // query and the unused code
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_idx        <= '0;
            r_cmp_act    <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_rsp_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_cmp_act    <= n_cmp_act;
            r_found      <= n_found;
            r_free_found <= n_free_found;
            r_rsp_valid  <= n_rsp_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_cmp_idx   <= n_cmp_idx;
        r_found_idx <= n_found_idx;
        r_cnt       <= n_cnt;
        r_free_idx  <= n_free_idx;
        r_rsp       <= n_rsp;
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire

// ----- sv/kct_checker.sv -----
// port-level checks of the keyed count table, bound to the top level
// depends on kct_pkg, assert_macros.svh, keyed_count_table
`default_nettype none
`include "assert_macros.svh"

module kct_checker (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_req_valid,
    input  wire logic  o_req_stall,
    input  wire logic  o_rsp_valid,
    input  wire logic  i_rsp_stall,
    input  wire kct_pkg::t_rsp o_rsp
);
    import kct_pkg::*;

    // a taken request keeps the block busy in the next cycle
    `KCT_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_req_valid && !o_req_stall, o_req_stall)

    // a full table never reports a count
    `KCT_ASSERT_NOW(a_full_zero, i_clk, i_rst_n,
        o_rsp_valid && (o_rsp.status == STS_FULL), o_rsp.count_after == '0)

    // a new result only comes out of a busy cycle
    `KCT_ASSERT_NOW(a_rsp_from_work, i_clk, i_rst_n, $rose(o_rsp_valid), $past(o_req_stall))

    // a stalled result holds
    `KCT_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && i_rsp_stall, o_rsp_valid && $stable(o_rsp))

endmodule

bind keyed_count_table kct_checker u_kct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_stall (o_req_stall),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_stall (i_rsp_stall),
    .o_rsp       (o_rsp)
);

`default_nettype wire
